// ===== sv/hcd_pkg.sv =====
// Shared types, codes and byte classifiers for the chunked body decoder.
`timescale 1ns / 1ps

package hcd_pkg;

  typedef enum logic [4:0] {
    PH_SIZE  = 5'b00001,
    PH_DATA  = 5'b00010,
    PH_CEND  = 5'b00100,
    PH_TRAIL = 5'b01000,
    PH_ERR   = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_TOO_LONG = 2'd0,
    ERR_BAD_SIZE = 2'd1,
    ERR_NO_CRLF  = 2'd2
  } err_e;

  localparam int unsigned LimitW   = 7;
  localparam int unsigned SizeW    = 31;
  localparam logic [LimitW-1:0] LimitReset = 7'd12;
  localparam logic [LimitW-1:0] LimitMin   = 7'd3;
  localparam logic [LimitW-1:0] LimitMax   = 7'd64;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef struct packed {
    logic             line_end;
    logic             bad;
    logic             too_long;
    logic [SizeW-1:0] size;
  } line_stat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       code;
  } result_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C);
  endfunction

endpackage

// ===== sv/hcd_size_line.sv =====
// Size line parser: hex accumulation, blank rules, length limit, CR LF end.
`timescale 1ns / 1ps

module hcd_size_line (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             clear_i,
  input  logic [7:0]                       byte_i,
  input  logic [hcd_pkg::LimitW-1:0]       limit_i,
  output hcd_pkg::line_stat_t              stat_o
);

  logic [hcd_pkg::LimitW-1:0] cnt_q, cnt_d, cnt_e, cnt_n;
  logic [hcd_pkg::SizeW-1:0]  acc_q, acc_d, acc_e;
  logic                       dig_q, dig_d, dig_e;
  logic                       tb_q, tb_d, tb_e;
  logic                       bad_q, bad_d, bad_e;
  logic                       cr_q, cr_d, cr_e;
  logic [4:0]                 hex;
  logic                       ovf;

  always_comb begin
    cnt_e = clear_i ? '0 : cnt_q;
    acc_e = clear_i ? '0 : acc_q;
    dig_e = clear_i ? 1'b0 : dig_q;
    tb_e  = clear_i ? 1'b0 : tb_q;
    bad_e = clear_i ? 1'b0 : bad_q;
    cr_e  = clear_i ? 1'b0 : cr_q;

    cnt_n = cnt_e + 7'd1;
    hex   = hcd_pkg::hex_digit(byte_i);
    ovf   = |acc_e[hcd_pkg::SizeW-1:hcd_pkg::SizeW-4];

    stat_o.line_end = cr_e && (byte_i == hcd_pkg::ChLf);
    stat_o.bad      = bad_e || !dig_e;
    stat_o.size     = acc_e;
    stat_o.too_long = 1'b0;

    cnt_d = cnt_e;
    acc_d = acc_e;
    dig_d = dig_e;
    tb_d  = tb_e;
    bad_d = bad_e;
    cr_d  = cr_e;

    if (step_i) begin
      if (stat_o.line_end) begin
        cnt_d = '0;
        acc_d = '0;
        dig_d = 1'b0;
        tb_d  = 1'b0;
        bad_d = 1'b0;
        cr_d  = 1'b0;
      end else begin
        cnt_d = cnt_n;
        cr_d  = (byte_i == hcd_pkg::ChCr);
        if (hex[4]) begin
          if (tb_e || ovf) begin
            bad_d = 1'b1;
          end else begin
            acc_d = {acc_e[hcd_pkg::SizeW-5:0], hex[3:0]};
          end
          dig_d = 1'b1;
        end else if (hcd_pkg::is_blank(byte_i)) begin
          if (dig_e) begin
            tb_d = 1'b1;
          end
        end else begin
          bad_d = 1'b1;
        end
        stat_o.too_long = (cnt_n >= limit_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
      dig_q <= 1'b0;
      tb_q  <= 1'b0;
      bad_q <= 1'b0;
      cr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      dig_q <= dig_d;
      tb_q  <= tb_d;
      bad_q <= bad_d;
      cr_q  <= cr_d;
    end
  end

endmodule

// ===== sv/hcd_out_stage.sv =====
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module hcd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hcd_pkg::result_t  res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hcd_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  hcd_pkg::result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== sv/http_chunked_decoder.sv =====
// A word that yields a result shows it on the outputs in the cycle after acceptance.
// Throughput: one word per cycle; input ready drops only while a result waits unaccepted.
// The phase register, chunk counter and size line state update in the cycle of acceptance.
// Reset (rst_ni low, asynchronous) clears the parser to the size line and sets the
// header limit to 12; start_message_i clears the parser only, before its word is handled.
`timescale 1ns / 1ps

module http_chunked_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       start_message_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic [1:0]                 event_kind_o,
  output logic [1:0]                 error_code_o,
  input  logic                       cfg_we_i,
  input  logic [hcd_pkg::LimitW-1:0] cfg_wdata_i
);

  logic [hcd_pkg::LimitW-1:0] limit_q, limit_c;
  hcd_pkg::phase_e            phase_q, phase_d, phase_e;
  logic [hcd_pkg::SizeW-1:0]  left_q, left_d, left_e, left_n;
  logic                       tail_q, tail_d, tail_e;
  logic                       ccr_q, ccr_d, ccr_e;
  logic                       accept, clear, push, free;
  hcd_pkg::line_stat_t        lstat;
  hcd_pkg::result_t           res, res_out;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;
  assign clear      = accept && start_message_i;

  always_comb begin
    limit_c = limit_q;
    if (limit_q < hcd_pkg::LimitMin) begin
      limit_c = hcd_pkg::LimitMin;
    end else if (limit_q > hcd_pkg::LimitMax) begin
      limit_c = hcd_pkg::LimitMax;
    end
  end

  assign phase_e = clear ? hcd_pkg::PH_SIZE : phase_q;
  assign left_e  = clear ? '0 : left_q;
  assign tail_e  = clear ? 1'b0 : tail_q;
  assign ccr_e   = clear ? 1'b0 : ccr_q;
  assign left_n  = left_e - 31'd1;

  hcd_size_line u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept && (phase_e == hcd_pkg::PH_SIZE)),
    .clear_i (clear),
    .byte_i  (in_byte_i),
    .limit_i (limit_c),
    .stat_o  (lstat)
  );

  always_comb begin
    phase_d      = phase_e;
    left_d       = left_e;
    tail_d       = tail_e;
    ccr_d        = ccr_e;
    push         = 1'b0;
    res.out_byte = 8'd0;
    res.kind     = hcd_pkg::KIND_DATA;
    res.code     = hcd_pkg::ERR_TOO_LONG;
    unique case (phase_e)
      hcd_pkg::PH_SIZE: begin
        if (lstat.line_end) begin
          if (lstat.bad) begin
            phase_d  = hcd_pkg::PH_ERR;
            push     = 1'b1;
            res.kind = hcd_pkg::KIND_ERROR;
            res.code = hcd_pkg::ERR_BAD_SIZE;
          end else if (lstat.size == '0) begin
            phase_d  = hcd_pkg::PH_TRAIL;
            push     = 1'b1;
            res.kind = hcd_pkg::KIND_END;
          end else begin
            phase_d = hcd_pkg::PH_DATA;
            left_d  = lstat.size;
          end
        end else if (lstat.too_long) begin
          phase_d  = hcd_pkg::PH_ERR;
          push     = 1'b1;
          res.kind = hcd_pkg::KIND_ERROR;
          res.code = hcd_pkg::ERR_TOO_LONG;
        end
      end
      hcd_pkg::PH_DATA: begin
        left_d       = left_n;
        push         = 1'b1;
        res.out_byte = in_byte_i;
        if (left_n == '0) begin
          phase_d = hcd_pkg::PH_CEND;
          tail_d  = 1'b0;
          ccr_d   = 1'b0;
        end
      end
      hcd_pkg::PH_CEND: begin
        if (!tail_e) begin
          ccr_d  = (in_byte_i == hcd_pkg::ChCr);
          tail_d = 1'b1;
        end else begin
          tail_d = 1'b0;
          ccr_d  = 1'b0;
          if (ccr_e && (in_byte_i == hcd_pkg::ChLf)) begin
            phase_d = hcd_pkg::PH_SIZE;
          end else begin
            phase_d  = hcd_pkg::PH_ERR;
            push     = 1'b1;
            res.kind = hcd_pkg::KIND_ERROR;
            res.code = hcd_pkg::ERR_NO_CRLF;
          end
        end
      end
      hcd_pkg::PH_TRAIL, hcd_pkg::PH_ERR: begin
      end
      default: begin
        phase_d = hcd_pkg::PH_ERR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hcd_pkg::LimitReset;
      phase_q <= hcd_pkg::PH_SIZE;
      left_q  <= '0;
      tail_q  <= 1'b0;
      ccr_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        left_q  <= left_d;
        tail_q  <= tail_d;
        ccr_q   <= ccr_d;
      end
    end
  end

  hcd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && push),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign out_byte_o   = res_out.out_byte;
  assign event_kind_o = res_out.kind;
  assign error_code_o = res_out.code;

endmodule

// ===== sv/hcd_checker.sv =====
// Port-level checks for the chunked body decoder, bound to the top level.
`timescale 1ns / 1ps

module hcd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [7:0]                 out_byte_o,
  input logic [1:0]                 event_kind_o,
  input logic [1:0]                 error_code_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(event_kind_o) && $stable(error_code_o))
    else $error("result word changed while stalled");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != hcd_pkg::KIND_DATA) |-> out_byte_o == 8'd0)
    else $error("nonzero byte on an event word");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != hcd_pkg::KIND_ERROR) |-> error_code_o == 2'd0)
    else $error("error code set on a non-error word");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with no pending result");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .event_kind_o (event_kind_o),
  .error_code_o (error_code_o)
);
